// ===== hw/rtl/frx_pkg.sv =====
package frx_pkg;

  // Default payload capacity of a frame, in bytes.
  localparam int unsigned MAX_PAYLOAD_DEF = 32;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PLEN_W   = 6;
  localparam int unsigned BIDX_W   = 5;
  localparam logic [BYTE_W-1:0] START_RESET = 8'hAA;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_start;  // open a frame, seed the running XOR
    logic load_cmd;    // capture the command byte
    logic load_len;    // capture the length byte, clear the byte counter
    logic store_byte;  // write a payload byte, advance the counter
    logic clr_count;   // rewind the counter before playback
    logic inc_count;   // step to the next stored byte
    logic rd_en;       // read the payload store at the counter
  } frx_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_match; // received byte equals the start byte
    logic len_ok;      // received length fits the payload store
    logic count_done;  // all payload bytes of the frame are in
    logic sum_match;   // received byte equals the running XOR
    logic empty;       // frame has no payload
    logic last_one;    // current playback result is the final one
  } frx_sts_t;

endpackage

// ===== hw/rtl/frx_ifs.sv =====
interface frx_in_if;
  import frx_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frx_out_if;
  import frx_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] command;
  logic [PLEN_W-1:0] payload_len;
  logic              has_payload;
  logic [BIDX_W-1:0] byte_index;
  logic [BYTE_W-1:0] payload_byte;
  logic              last;

  modport source (output valid, output command, output payload_len, output has_payload,
                  output byte_index, output payload_byte, output last, input ready);
  modport sink   (input valid, input command, input payload_len, input has_payload,
                  input byte_index, input payload_byte, input last, output ready);
endinterface

// ===== hw/rtl/frx_datapath.sv =====
module frx_datapath #(
  parameter int unsigned MAX_PAYLOAD = frx_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [frx_pkg::BYTE_W-1:0] cfg_data,
  input  logic [frx_pkg::BYTE_W-1:0] rx_byte,
  input  frx_pkg::frx_ctl_t         ctl,
  output frx_pkg::frx_sts_t         sts,
  output logic [frx_pkg::BYTE_W-1:0] command,
  output logic [frx_pkg::PLEN_W-1:0] payload_len,
  output logic                      has_payload,
  output logic [frx_pkg::BIDX_W-1:0] byte_index,
  output logic [frx_pkg::BYTE_W-1:0] payload_byte,
  output logic                      last
);
  import frx_pkg::*;

  localparam int unsigned LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] running_xor;
  logic [BYTE_W-1:0] frame_command;
  logic [LEN_W-1:0]  frame_length;
  logic [LEN_W-1:0]  count;
  logic [BYTE_W-1:0] rdata;
  logic [BYTE_W-1:0] payload_store [MAX_PAYLOAD];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte    <= START_RESET;
      running_xor   <= '0;
      frame_command <= '0;
      frame_length  <= '0;
      count         <= '0;
    end else begin
      if (cfg_we) begin
        start_byte <= cfg_data;
      end
      if (ctl.load_start) begin
        running_xor <= rx_byte;
      end
      if (ctl.load_cmd) begin
        running_xor   <= running_xor ^ rx_byte;
        frame_command <= rx_byte;
      end
      if (ctl.load_len) begin
        running_xor  <= running_xor ^ rx_byte;
        frame_length <= LEN_W'(rx_byte);
        count        <= '0;
      end
      if (ctl.store_byte) begin
        running_xor <= running_xor ^ rx_byte;
        count       <= count + LEN_W'(1);
      end
      if (ctl.clr_count) begin
        count <= '0;
      end
      if (ctl.inc_count) begin
        count <= count + LEN_W'(1);
      end
    end
  end

  // Payload store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.store_byte) begin
      payload_store[count[ADDR_W-1:0]] <= rx_byte;
    end
    if (ctl.rd_en) begin
      rdata <= payload_store[count[ADDR_W-1:0]];
    end
  end

  always_comb begin
    sts.start_match = (rx_byte == start_byte);
    sts.len_ok      = (rx_byte <= BYTE_W'(MAX_PAYLOAD));
    sts.count_done  = (count == frame_length);
    sts.sum_match   = (rx_byte == running_xor);
    sts.empty       = (frame_length == '0);
    sts.last_one    = sts.empty || ((count + LEN_W'(1)) == frame_length);
  end

  assign command      = frame_command;
  assign payload_len  = PLEN_W'(frame_length);
  assign has_payload  = !sts.empty;
  assign byte_index   = BIDX_W'(count);
  assign payload_byte = sts.empty ? '0 : rdata;
  assign last         = sts.last_one;

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= frame_length)
    else $error("byte counter ran past the frame length");

  a_len_capped: assert property (@(posedge clk) disable iff (rst)
    ctl.load_len |=> frame_length <= LEN_W'(MAX_PAYLOAD))
    else $error("stored frame length exceeds capacity");

  a_store_bounded: assert property (@(posedge clk) disable iff (rst)
    ctl.store_byte |-> count < frame_length)
    else $error("payload write beyond the frame length");

endmodule

// ===== hw/rtl/frx_ctrl.sv =====
module frx_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  frx_pkg::frx_sts_t sts,
  output frx_pkg::frx_ctl_t ctl
);
  import frx_pkg::*;

  typedef enum logic [5:0] {
    HUNT = 6'b000001,
    CMD  = 6'b000010,
    LEN  = 6'b000100,
    DATA = 6'b001000,
    READ = 6'b010000,
    SHOW = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_fire;
  logic   out_fire;

  assign in_ready  = (state == HUNT) || (state == CMD) || (state == LEN) || (state == DATA);
  assign out_valid = (state == SHOW);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      HUNT: begin
        if (in_fire && sts.start_match) begin
          ctl.load_start = 1'b1;
          state_next     = CMD;
        end
      end
      CMD: begin
        if (in_fire) begin
          ctl.load_cmd = 1'b1;
          state_next   = LEN;
        end
      end
      LEN: begin
        if (in_fire) begin
          if (sts.len_ok) begin
            ctl.load_len = 1'b1;
            state_next   = DATA;
          end else begin
            state_next = HUNT;
          end
        end
      end
      DATA: begin
        if (in_fire) begin
          if (!sts.count_done) begin
            ctl.store_byte = 1'b1;
          end else if (sts.sum_match) begin
            ctl.clr_count = 1'b1;
            state_next    = sts.empty ? SHOW : READ;
          end else begin
            state_next = HUNT;
          end
        end
      end
      READ: begin
        ctl.rd_en  = 1'b1;
        state_next = SHOW;
      end
      SHOW: begin
        if (out_fire) begin
          if (sts.last_one) begin
            state_next = HUNT;
          end else begin
            ctl.inc_count = 1'b1;
            state_next    = READ;
          end
        end
      end
      default: state_next = HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HUNT;
    end else begin
      state <= state_next;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_fire && sts.last_one |=> state == HUNT)
    else $error("frame playback did not end on the last result");

  a_bad_sum: assert property (@(posedge clk) disable iff (rst)
    in_fire && state == DATA && sts.count_done && !sts.sum_match |=> state == HUNT)
    else $error("checksum mismatch did not drop the frame");

endmodule

// ===== hw/rtl/frame_receiver_xor_check_core.sv =====
// After the checksum byte's transfer the controller reads the payload store in
// READ and then offers the result in SHOW; empty frames go straight to SHOW.
// Throughput: one received byte per cycle while a frame is collected; each
// playback result is read from the payload store's single read port, then shown.
// Reset (rst, synchronous, active high): hunting for a start byte, start byte
// 0xAA, checksum and header registers cleared; payload store is not cleared.
module frame_receiver_xor_check_core #(
  parameter int unsigned MAX_PAYLOAD = frx_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [frx_pkg::BYTE_W-1:0] cfg_data,
  frx_in_if.sink                     in_ch,
  frx_out_if.source                  out_ch
);
  import frx_pkg::*;

  // The controller sequences the frame: start hunt, command, length, payload
  // collection and checksum, then playback of the stored payload. Input
  // transfers are refused during playback, so one frame is in flight at a time.
  frx_ctl_t ctl;
  frx_sts_t sts;

  frx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // The datapath holds the start byte register, the running XOR, the header
  // fields, the byte counter and the payload store. Its result fields are
  // taken straight from registers, so they hold steady while a result waits
  // for its transfer.
  frx_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .rx_byte      (in_ch.rx_byte),
    .ctl          (ctl),
    .sts          (sts),
    .command      (out_ch.command),
    .payload_len  (out_ch.payload_len),
    .has_payload  (out_ch.has_payload),
    .byte_index   (out_ch.byte_index),
    .payload_byte (out_ch.payload_byte),
    .last         (out_ch.last)
  );

endmodule
